// ===== rtl/mpcm_pkg.sv =====
`timescale 1ns / 1ps
package mpcm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_VOLUME = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [15:0] COUNT_STEP_RESET = 16'd320;
    localparam logic [15:0] GAIN_RESET       = 16'd10363;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         channel_index;
        logic [15:0]        mem_address;
        logic signed [15:0] sample_value;
        logic [15:0]        play_length;
        logic [15:0]        skip_ticks;
        logic [7:0]         volume_code;
    } in_word_t;

    typedef struct packed {
        logic signed [18:0] mixed_sample;
        logic [7:0]         active_mask;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic          load;      // latch command word
        logic          apply;     // apply non-tick command
        logic          clr_sum;
        logic          chan_eval; // evaluate channel, issue read if due
        logic          chan_acc;  // accumulate read data for channel
        logic [CH_W-1:0] chan;
        logic          emit;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic due;     // evaluated channel needs a sample read
    } stat_t;

    function automatic logic [15:0] gain_of(input logic [7:0] idx);
        logic [15:0] g;
        begin
            unique case (idx)
                8'd0: g = 5; 8'd1: g = 6; 8'd2: g = 6; 8'd3: g = 7; 8'd4: g = 7;
                8'd5: g = 8; 8'd6: g = 9; 8'd7: g = 10; 8'd8: g = 10; 8'd9: g = 11;
                8'd10: g = 12; 8'd11: g = 14; 8'd12: g = 15; 8'd13: g = 16;
                8'd14: g = 18; 8'd15: g = 20; 8'd16: g = 21; 8'd17: g = 23;
                8'd18: g = 25; 8'd19: g = 29; 8'd20: g = 31; 8'd21: g = 33;
                8'd22: g = 37; 8'd23: g = 41; 8'd24: g = 46; 8'd25: g = 50;
                8'd26: g = 54; 8'd27: g = 60; 8'd28: g = 66; 8'd29: g = 72;
                8'd30: g = 80; 8'd31: g = 89; 8'd32: g = 97; 8'd33: g = 107;
                8'd34: g = 117; 8'd35: g = 130; 8'd36: g = 142; 8'd37: g = 156;
                8'd38: g = 173; 8'd39: g = 189; 8'd40: g = 205; 8'd41: g = 226;
                8'd42: g = 246; 8'd43: g = 267; 8'd44: g = 308; 8'd45: g = 328;
                8'd46: g = 369; 8'd47: g = 410; 8'd48: g = 431; 8'd49: g = 492;
                8'd50: g = 533; 8'd51: g = 594; 8'd52: g = 656; 8'd53: g = 717;
                8'd54: g = 799; 8'd55: g = 861; 8'd56: g = 963; 8'd57: g = 1045;
                8'd58: g = 1147; 8'd59: g = 1270; 8'd60: g = 1393; 8'd61: g = 1536;
                8'd62: g = 1700; 8'd63: g = 1864; 8'd64: g = 2048; 8'd65: g = 2253;
                8'd66: g = 2479; 8'd67: g = 2724; 8'd68: g = 2991; 8'd69: g = 3298;
                8'd70: g = 3625; 8'd71: g = 3994; 8'd72: g = 4383; 8'd73: g = 4834;
                8'd74: g = 5325; 8'd75: g = 5837; 8'd76: g = 6431; 8'd77: g = 7087;
                8'd78: g = 7783; 8'd79: g = 8561; 8'd80: g = 9442; 8'd81: g = 10363;
                8'd82: g = 11387; 8'd83: g = 12555; 8'd84: g = 13824;
                8'd85: g = 15217; 8'd86: g = 16733; 8'd87: g = 18371;
                8'd88: g = 20255; 8'd89: g = 22221; 8'd90: g = 24454;
                8'd91: g = 26932; 8'd92: g = 29696; 8'd93: g = 32768;
                8'd94: g = 36127; 8'd95: g = 39732; 8'd96: g = 43541;
                default: g = 0;
            endcase
            return g;
        end
    endfunction

    function automatic logic [7:0] low_map(input logic [3:0] c);
        logic [7:0] m;
        begin
            unique case (c)
                4'd0: m = 8'h6B; 4'd1: m = 8'h6F; 4'd2: m = 8'h71; 4'd3: m = 8'h74;
                4'd4: m = 8'h76; 4'd5: m = 8'h79; 4'd6: m = 8'h7B; 4'd7: m = 8'h7D;
                4'd8: m = 8'h80; 4'd9: m = 8'h82; 4'd10: m = 8'h84; 4'd11: m = 8'h87;
                4'd12: m = 8'h8A; 4'd13: m = 8'h8C; 4'd14: m = 8'h8F;
                default: m = 8'h91;
            endcase
            return m;
        end
    endfunction

    function automatic logic [15:0] code_to_gain(input logic [7:0] code);
        logic [15:0] g;
        begin
            if (code <= 8'd15)
                g = gain_of(low_map(code[3:0]) - 8'h40);
            else if (code >= 8'h40 && code <= 8'hA0)
                g = gain_of(code - 8'h40);
            else
                g = 16'd0;
            return g;
        end
    endfunction

endpackage

// ===== rtl/mpcm_ram.sv =====
`timescale 1ns / 1ps
module mpcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/mpcm_ctrl.sv =====
`timescale 1ns / 1ps
module mpcm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mpcm_pkg::stat_t stat,
    output mpcm_pkg::ctrl_t ctrl
);
    import mpcm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CH_W-1:0] chan_reg, chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        ctrl       = '0;
        ctrl.chan  = chan_reg;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                chan_next = '0;
                if (stat.is_tick)
                begin
                    ctrl.clr_sum = 1'b1;
                    state_next   = S_EVAL;
                end
                else
                begin
                    ctrl.apply = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVAL:
            begin
                ctrl.chan_eval = 1'b1;
                if (stat.due)
                begin
                    state_next = S_READ;
                end
                else if (chan_reg == CH_W'(NUM_CHANNELS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctrl.chan_acc = 1'b1;
                if (chan_reg == CH_W'(NUM_CHANNELS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EMIT:
            begin
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/mpcm_dp.sv =====
`timescale 1ns / 1ps
module mpcm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mpcm_pkg::in_word_t  cmd,
    input  logic                cfg_valid,
    input  logic [15:0]         cfg_data,
    input  mpcm_pkg::ctrl_t     ctrl,
    output mpcm_pkg::stat_t     stat,
    output mpcm_pkg::out_word_t result,
    output logic                result_valid
);
    import mpcm_pkg::*;

    in_word_t    cmd_reg;
    logic [15:0] step_reg;

    logic [ADDR_W-1:0] start_reg [NUM_CHANNELS];
    logic [15:0]       len_reg   [NUM_CHANNELS];
    logic [15:0]       pos_reg   [NUM_CHANNELS];
    logic [16:0]       wait_reg  [NUM_CHANNELS];
    logic [15:0]       skip_reg  [NUM_CHANNELS];
    logic [15:0]       gain_reg  [NUM_CHANNELS];
    logic              fin_reg   [NUM_CHANNELS];

    logic signed [22:0] sum_reg;
    logic signed [32:0] prod_reg;
    out_word_t          res_reg;
    logic               res_vld_reg;

    logic [15:0]       rdata;
    logic [ADDR_W-1:0] raddr;
    logic              in_range;
    logic              live;
    logic [CH_W-1:0]   c;
    logic [CH_W-1:0]   ci;
    logic [16:0]       pos_inc;

    assign c        = ctrl.chan;
    assign ci       = cmd_reg.channel_index[CH_W-1:0];
    assign in_range = ({1'b0, cmd_reg.channel_index} < 4'(NUM_CHANNELS));
    assign live     = (len_reg[c] != 16'd0) && !fin_reg[c];
    assign stat.is_tick = (cmd_reg.command == CMD_TICK);
    assign stat.due     = live && (wait_reg[c] >= {1'b0, skip_reg[c]});
    assign raddr        = start_reg[c] + pos_reg[c][ADDR_W-1:0];
    assign pos_inc      = {1'b0, pos_reg[c]} + 17'd1;

    mpcm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_mem (
        .clk   (clk),
        .we    (ctrl.apply && cmd_reg.command == CMD_WRITE),
        .waddr (cmd_reg.mem_address[ADDR_W-1:0]),
        .wdata (cmd_reg.sample_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // scale and clamp of the registered product
    logic signed [32:0] q;
    logic signed [22:0] clamped;
    always_comb
    begin
        q = prod_reg / 1024;
        if (q > 33'sd32767)
            clamped = 23'sd32767;
        else if (q < -33'sd32767)
            clamped = -23'sd32767;
        else
            clamped = 23'(q);
    end

    logic [7:0] mask;
    logic signed [18:0] sat;
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < NUM_CHANNELS && i < 8; i++)
        begin
            mask[i] = (len_reg[i] != 16'd0);
        end
        if (sum_reg > 23'sd262143)
            sat = 19'sd262143;
        else if (sum_reg < -23'sd262144)
            sat = -19'sd262144;
        else
            sat = 19'(sum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
        prod_reg <= $signed(rdata) * $signed({1'b0, gain_reg[c]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= COUNT_STEP_RESET;
            sum_reg      <= '0;
            res_reg      <= '0;
            res_vld_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
                pos_reg[i]   <= '0;
                wait_reg[i]  <= '0;
                skip_reg[i]  <= '0;
                gain_reg[i]  <= GAIN_RESET;
                fin_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            res_vld_reg  <= ctrl.emit;
            if (cfg_valid)
            begin
                step_reg <= cfg_data;
            end
            if (ctrl.emit)
            begin
                res_reg.mixed_sample <= sat;
                res_reg.active_mask  <= mask;
            end
            if (ctrl.clr_sum)
            begin
                sum_reg <= '0;
            end
            if (ctrl.chan_eval && live)
            begin
                if (stat.due)
                begin
                    wait_reg[c] <= '0;
                    if (pos_inc >= {1'b0, len_reg[c]})
                    begin
                        pos_reg[c] <= '0;
                        fin_reg[c] <= 1'b1;
                    end
                    else
                    begin
                        pos_reg[c] <= pos_inc[15:0];
                    end
                end
                else
                begin
                    wait_reg[c] <= wait_reg[c] + {1'b0, step_reg};
                end
            end
            if (ctrl.chan_acc)
            begin
                sum_reg <= sum_reg + clamped;
            end
            if (ctrl.apply && in_range)
            begin
                unique case (cmd_reg.command)
                    CMD_START:
                    begin
                        start_reg[ci[CH_W-1:0]] <= cmd_reg.mem_address[ADDR_W-1:0];
                        len_reg[ci[CH_W-1:0]]   <= cmd_reg.play_length;
                        skip_reg[ci[CH_W-1:0]]  <= cmd_reg.skip_ticks;
                        wait_reg[ci[CH_W-1:0]]  <= '0;
                        fin_reg[ci[CH_W-1:0]]   <= 1'b0;
                        gain_reg[ci[CH_W-1:0]]  <= code_to_gain(cmd_reg.volume_code);
                        pos_reg[ci[CH_W-1:0]]   <= '0;
                    end
                    CMD_STOP:
                    begin
                        len_reg[ci[CH_W-1:0]]  <= '0;
                        gain_reg[ci[CH_W-1:0]] <= '0;
                        pos_reg[ci[CH_W-1:0]]  <= '0;
                        wait_reg[ci[CH_W-1:0]] <= '0;
                        fin_reg[ci[CH_W-1:0]]  <= 1'b0;
                    end
                    CMD_VOLUME:
                    begin
                        gain_reg[ci[CH_W-1:0]] <= code_to_gain(cmd_reg.volume_code);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign result       = res_reg;
    assign result_valid = res_vld_reg;
endmodule

// ===== rtl/multichannel_pcm_sample_mixer_unit.sv =====
`timescale 1ns / 1ps
// Eight-channel PCM mixer. A command word is taken when start is high and busy
// is low. Write, start, stop and volume commands are latched, then applied,
// and give no output. A tick walks the channels one at a time through one
// sample memory read port; a channel that is due for a sample is read and
// its sample accumulated. After the last channel the mix word shows on result
// for one cycle with result_valid high and cannot be held off.
// count_step may be written through cfg_valid/cfg_ready at any time idle.
module multichannel_pcm_sample_mixer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mpcm_pkg::in_word_t  cmd,
    output mpcm_pkg::out_word_t result,
    output logic                result_valid,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import mpcm_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mpcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    mpcm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef NO_ASSERTIONS
    a_no_start_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$past(result_valid)) else $error("back to back results");
    a_emit_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> result_valid && !busy) else $error("result not presented");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.apply, ctrl.chan_eval, ctrl.chan_acc, ctrl.emit}))
        else $error("controller phases overlap");
`endif
endmodule
